@@ src/tcas_pkg.sv @@
// tcas_pkg: shared widths, configuration register codes and small structs
// for the ring-road traffic automaton. No dependencies.
package tcas_pkg;

  localparam int LenW     = 13;  // track length / car count registers
  localparam int SpdW     = 5;   // speed field
  localparam int PctW     = 7;   // slow percent
  localparam int DrawW    = 7;   // random draw
  localparam int OutIdxW  = 12;  // car_index port
  localparam int OutPosW  = 12;  // new_position port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTrackLen = 2'd0,
    CfgNumCars  = 2'd1,
    CfgMaxSpeed = 2'd2,
    CfgSlowPct  = 2'd3
  } cfg_idx_e;

  localparam logic [LenW-1:0] RstTrackLen = 13'd1024;
  localparam logic [LenW-1:0] RstNumCars  = 13'd256;
  localparam logic [SpdW-1:0] RstMaxSpeed = 5'd5;
  localparam logic [PctW-1:0] RstSlowPct  = 7'd25;

  // effective (saturated) configuration seen by the datapath
  typedef struct packed {
    logic [LenW-1:0] track_len;
    logic [LenW-1:0] num_cars;
    logic [SpdW-1:0] max_speed;
    logic [PctW-1:0] slow_pct;
  } cfg_t;

  // remainder unit status
  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

@@ src/tcas_front.sv @@
// tcas_front: accepts draws and assigns each one the next car in round-robin
// order. Depends on tcas_pkg.
module tcas_front #(
  parameter int CarW = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tcas_pkg::DrawW-1:0] random_draw_i,
  input  logic [tcas_pkg::LenW-1:0]  num_cars_i,
  input  logic                       full_i,
  output logic                       push_o,
  output logic [CarW-1:0]            car_idx_o,
  output logic                       last_o,
  output logic [tcas_pkg::DrawW-1:0] draw_o
);

  logic [CarW-1:0] next_car_q, next_car_d;
  logic            accept;

  assign accept     = in_valid_i & ~full_i;
  assign in_stall_o = full_i;
  assign push_o     = accept;
  assign draw_o     = random_draw_i;

  always_comb begin
    car_idx_o = next_car_q;
    // count shrunk mid-sweep: restart at car 0
    if (32'(next_car_q) >= 32'(num_cars_i)) begin
      car_idx_o = '0;
    end
    last_o = (32'(car_idx_o) == (32'(num_cars_i) - 32'd1));
    next_car_d = next_car_q;
    if (accept) begin
      next_car_d = last_o ? '0 : car_idx_o + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_car_q <= '0;
    end else begin
      next_car_q <= next_car_d;
    end
  end

endmodule

@@ src/tcas_fifo.sv @@
// tcas_fifo: small register FIFO that decouples the front from the back.
// No dependencies.
module tcas_fifo #(
  parameter int Width = 20,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ src/tcas_rem.sv @@
// tcas_rem: iterative remainder unit, one dividend bit per cycle.
// Depends on tcas_pkg.
module tcas_rem #(
  parameter int DivW = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DivW-1:0]           dividend_i,
  input  logic [tcas_pkg::LenW-1:0] divisor_i,
  output tcas_pkg::rem_stat_t       stat_o,
  output logic [tcas_pkg::LenW-1:0] result_o
);

  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0]           dvd_q, dvd_d;
  logic [tcas_pkg::LenW-1:0] rem_q, rem_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic [tcas_pkg::LenW:0]   trial;

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = rem_q;

  always_comb begin
    trial  = {rem_q, dvd_q[DivW-1]};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // restoring step: remainder stays below the divisor
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = tcas_pkg::LenW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[tcas_pkg::LenW-1:0];
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

endmodule

@@ src/tcas_back.sv @@
// tcas_back: car state memories, read/forward stage, update datapath and
// output register. Depends on tcas_pkg and tcas_rem.
module tcas_back #(
  parameter int CarW    = 12,
  parameter int PosW    = 12,
  parameter int MaxCars = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcas_pkg::cfg_t               cfg_i,
  input  logic                         q_empty_i,
  input  logic [CarW-1:0]              q_car_idx_i,
  input  logic                         q_last_i,
  input  logic [tcas_pkg::DrawW-1:0]   q_draw_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tcas_pkg::OutIdxW-1:0] car_index_o,
  output logic [tcas_pkg::OutPosW-1:0] new_position_o,
  output logic [tcas_pkg::SpdW-1:0]    new_speed_o,
  output logic                         sweep_done_o
);

  localparam int LenW = tcas_pkg::LenW;
  localparam int SpdW = tcas_pkg::SpdW;
  localparam int AW   = ((PosW > LenW) ? PosW : LenW) + 1;

  // state memories; entries at or above the fill count read as reset values
  logic [PosW-1:0] pos_mem [MaxCars];
  logic [SpdW-1:0] spd_mem [MaxCars];
  logic [PosW-1:0] self_rd_q, ahead_rd_q;
  logic [SpdW-1:0] spd_rd_q;

  logic [CarW:0]   fill_q, fill_d;
  logic [PosW-1:0] first_old_q;

  // update stage
  logic                       b2_valid_q, b2_valid_d;
  logic [CarW-1:0]            b2_idx_q;
  logic                       b2_last_q;
  logic [tcas_pkg::DrawW-1:0] b2_draw_q;
  logic                       fwd_self_q, fwd_ahead_q, init_self_q, init_ahead_q;
  logic [PosW-1:0]            fwd_pos_q;
  logic [SpdW-1:0]            fwd_spd_q;
  logic                       self_fixed_q, ahead_fixed_q, rem_tgt_ahead_q;
  logic [PosW-1:0]            self_fix_q, ahead_fix_q;

  logic                issue, b2_adv, ready;
  logic [CarW-1:0]     rd_idx_nx;
  logic [PosW-1:0]     self_sel, ahead_next, ahead_raw, self_val, ahead_val;
  logic [SpdW-1:0]     spd_sel;
  logic                need_self, need_ahead;
  logic [AW-1:0]       pos_a, ahd_a, len_a, gap, sum;
  logic [SpdW:0]       spd_inc, v1;
  logic [SpdW-1:0]     v2, new_spd;
  logic                slow;
  logic [PosW-1:0]     new_pos;

  logic                rem_start;
  tcas_pkg::rem_stat_t rem_stat;
  logic [LenW-1:0]     rem_result;

  logic                         out_valid_q;
  logic [tcas_pkg::OutIdxW-1:0] car_index_q;
  logic [tcas_pkg::OutPosW-1:0] new_position_q;
  logic [SpdW-1:0]              new_speed_q;
  logic                         sweep_done_q;

  assign rd_idx_nx = q_car_idx_i + 1'b1;
  assign issue     = ~q_empty_i & (~b2_valid_q | b2_adv);
  assign pop_o     = issue;

  // operand selection: forward the write done at issue, else reset value, else the memory read
  always_comb begin
    if (fwd_self_q) begin
      self_sel = fwd_pos_q;
      spd_sel  = fwd_spd_q;
    end else if (init_self_q) begin
      self_sel = PosW'(b2_idx_q);
      spd_sel  = '0;
    end else begin
      self_sel = self_rd_q;
      spd_sel  = spd_rd_q;
    end
    if (fwd_ahead_q) begin
      ahead_next = fwd_pos_q;
    end else if (init_ahead_q) begin
      ahead_next = PosW'(b2_idx_q + 1'b1);
    end else begin
      ahead_next = ahead_rd_q;
    end
    // last car looks at car 0 as it was at sweep start
    if (b2_last_q) begin
      ahead_raw = (b2_idx_q == '0) ? self_sel : first_old_q;
    end else begin
      ahead_raw = ahead_next;
    end
    self_val  = self_fixed_q ? self_fix_q : self_sel;
    ahead_val = ahead_fixed_q ? ahead_fix_q : ahead_raw;
    need_self  = b2_valid_q & (AW'(self_val) >= AW'(cfg_i.track_len));
    need_ahead = b2_valid_q & (AW'(ahead_val) >= AW'(cfg_i.track_len));
  end

  assign ready  = ~need_self & ~need_ahead;
  assign b2_adv = b2_valid_q & ready & (~out_valid_q | ~out_stall_i);

  // car update
  always_comb begin
    pos_a = AW'(self_val);
    ahd_a = AW'(ahead_val);
    len_a = AW'(cfg_i.track_len);
    if (ahd_a >= pos_a + AW'(1)) begin
      gap = ahd_a - pos_a - AW'(1);
    end else begin
      gap = ahd_a + len_a - pos_a - AW'(1);
    end
    spd_inc = {1'b0, spd_sel} + 1'b1;
    v1 = (spd_inc <= {1'b0, cfg_i.max_speed}) ? spd_inc : {1'b0, spd_sel};
    v2 = (gap < AW'(v1)) ? gap[SpdW-1:0] : v1[SpdW-1:0];
    slow = (v2 != '0) &&
           (({1'b0, b2_draw_q} + 1'b1) <= {1'b0, cfg_i.slow_pct});
    new_spd = slow ? v2 - 1'b1 : v2;
    sum = pos_a + AW'(new_spd);
    new_pos = (sum >= len_a) ? PosW'(sum - len_a) : PosW'(sum);
  end

  // stale positions go through the remainder unit, self first
  assign rem_start = (need_self | need_ahead) & ~rem_stat.busy & ~rem_stat.done;

  tcas_rem #(
    .DivW (PosW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (need_self ? self_val : ahead_val),
    .divisor_i  (cfg_i.track_len),
    .stat_o     (rem_stat),
    .result_o   (rem_result)
  );

  always_comb begin
    b2_valid_d = b2_valid_q;
    if (issue) begin
      b2_valid_d = 1'b1;
    end else if (b2_adv) begin
      b2_valid_d = 1'b0;
    end
    fill_d = fill_q;
    if (b2_adv && (32'(b2_idx_q) == 32'(fill_q))) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_valid_q      <= 1'b0;
      fill_q          <= '0;
      first_old_q     <= '0;
      self_fixed_q    <= 1'b0;
      ahead_fixed_q   <= 1'b0;
      rem_tgt_ahead_q <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      b2_valid_q <= b2_valid_d;
      fill_q     <= fill_d;
      if (b2_adv && (b2_idx_q == '0)) begin
        first_old_q <= self_sel;
      end
      if (issue) begin
        self_fixed_q  <= 1'b0;
        ahead_fixed_q <= 1'b0;
      end else if (rem_stat.done) begin
        if (rem_tgt_ahead_q) begin
          ahead_fixed_q <= 1'b1;
        end else begin
          self_fixed_q <= 1'b1;
        end
      end
      if (rem_start) begin
        rem_tgt_ahead_q <= ~need_self;
      end
      if (b2_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b2_idx_q     <= q_car_idx_i;
      b2_last_q    <= q_last_i;
      b2_draw_q    <= q_draw_i;
      fwd_self_q   <= b2_adv & (q_car_idx_i == b2_idx_q);
      fwd_ahead_q  <= b2_adv & (rd_idx_nx == b2_idx_q);
      init_self_q  <= (32'(q_car_idx_i) >= 32'(fill_q));
      init_ahead_q <= (32'(rd_idx_nx) >= 32'(fill_q));
      fwd_pos_q    <= new_pos;
      fwd_spd_q    <= new_spd;
    end
    if (rem_stat.done) begin
      if (rem_tgt_ahead_q) begin
        ahead_fix_q <= PosW'(rem_result);
      end else begin
        self_fix_q <= PosW'(rem_result);
      end
    end
    if (b2_adv) begin
      car_index_q    <= tcas_pkg::OutIdxW'(b2_idx_q);
      new_position_q <= tcas_pkg::OutPosW'(new_pos);
      new_speed_q    <= new_spd;
      sweep_done_q   <= b2_last_q;
    end
  end

  // memories: registered read-first ports, one write port each
  always_ff @(posedge clk_i) begin
    if (issue) begin
      self_rd_q  <= pos_mem[q_car_idx_i];
      ahead_rd_q <= pos_mem[rd_idx_nx];
      spd_rd_q   <= spd_mem[q_car_idx_i];
    end
    if (b2_adv) begin
      pos_mem[b2_idx_q] <= new_pos;
      spd_mem[b2_idx_q] <= new_spd;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign car_index_o    = car_index_q;
  assign new_position_o = new_position_q;
  assign new_speed_o    = new_speed_q;
  assign sweep_done_o   = sweep_done_q;

endmodule

@@ src/traffic_cellular_automaton_step_top.sv @@
// traffic_cellular_automaton_step_top: top level of the ring-road traffic
// automaton. Depends on tcas_pkg, tcas_front, tcas_fifo and tcas_back.

// Single-lane ring-road traffic automaton after the Nagel-Schreckenberg
// rules. Each accepted transaction on the input channel carries one random
// draw and updates the next car in round-robin order; each produces exactly
// one result transaction with the car index, its new position and speed, and
// a flag on the last car of a sweep. Throughput is one transaction per clock
// while the result channel does not stall and no stale position is being
// reduced: the front assigns car indexes, a two-entry queue separates it
// from the back, and the back reads the car's position, the position of the
// car ahead and the speed from on-chip memories into registers and writes
// the update when the car moves on to the output register. Results of
// back-to-back cars that touch the same entry are forwarded around the
// memories. After track_length is lowered, each stored position at or
// beyond the new length is reduced by a bit-serial remainder unit, which
// holds that car for each stale value (at most two per car, each reduced
// once since the write-back is reduced). Memory reset values come from a
// fill count, so there is no clearing pass after reset. Configuration
// writes take effect on the next clock and are meant for idle periods only.
module traffic_cellular_automaton_step_top #(
  parameter int MAX_CELLS = 4096,
  parameter int MAX_CARS  = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tcas_pkg::DrawW-1:0]      random_draw_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tcas_pkg::OutIdxW-1:0]    car_index_o,
  output logic [tcas_pkg::OutPosW-1:0]    new_position_o,
  output logic [tcas_pkg::SpdW-1:0]       new_speed_o,
  output logic                            sweep_done_o,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [tcas_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tcas_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int LenW  = tcas_pkg::LenW;
  localparam int CarW  = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
  // positions must hold cell numbers and the reset value "entry i holds i"
  localparam int CellW = $clog2(MAX_CELLS);
  localparam int PosW  = (CellW > CarW) ? CellW : CarW;
  localparam int QW    = CarW + 1 + tcas_pkg::DrawW;

  // configuration registers, raw as written
  logic [LenW-1:0]           track_len_q, track_len_d;
  logic [LenW-1:0]           num_cars_q, num_cars_d;
  logic [tcas_pkg::SpdW-1:0] max_speed_q, max_speed_d;
  logic [tcas_pkg::PctW-1:0] slow_pct_q, slow_pct_d;
  tcas_pkg::cfg_t            cfg_eff;

  always_comb begin
    track_len_d = track_len_q;
    num_cars_d  = num_cars_q;
    max_speed_d = max_speed_q;
    slow_pct_d  = slow_pct_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tcas_pkg::CfgTrackLen: track_len_d = cfg_data_i[LenW-1:0];
        tcas_pkg::CfgNumCars:  num_cars_d  = cfg_data_i[LenW-1:0];
        tcas_pkg::CfgMaxSpeed: max_speed_d = cfg_data_i[tcas_pkg::SpdW-1:0];
        tcas_pkg::CfgSlowPct:  slow_pct_d  = cfg_data_i[tcas_pkg::PctW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_len_q <= tcas_pkg::RstTrackLen;
      num_cars_q  <= tcas_pkg::RstNumCars;
      max_speed_q <= tcas_pkg::RstMaxSpeed;
      slow_pct_q  <= tcas_pkg::RstSlowPct;
    end else begin
      track_len_q <= track_len_d;
      num_cars_q  <= num_cars_d;
      max_speed_q <= max_speed_d;
      slow_pct_q  <= slow_pct_d;
    end
  end

  // saturation: zero counts as one, length capped at MAX_CELLS, car count
  // capped at the length and at MAX_CARS
  always_comb begin
    cfg_eff.track_len = track_len_q;
    if (track_len_q == '0) begin
      cfg_eff.track_len = LenW'(1);
    end
    if (32'(track_len_q) > 32'(MAX_CELLS)) begin
      cfg_eff.track_len = LenW'(MAX_CELLS);
    end
    cfg_eff.num_cars = num_cars_q;
    if (num_cars_q == '0) begin
      cfg_eff.num_cars = LenW'(1);
    end
    if (cfg_eff.num_cars > cfg_eff.track_len) begin
      cfg_eff.num_cars = cfg_eff.track_len;
    end
    if (32'(cfg_eff.num_cars) > 32'(MAX_CARS)) begin
      cfg_eff.num_cars = LenW'(MAX_CARS);
    end
    cfg_eff.max_speed = max_speed_q;
    cfg_eff.slow_pct  = slow_pct_q;
  end

  // front -> queue -> back
  logic                       q_full, q_empty, q_push, q_pop;
  logic [CarW-1:0]            f_car_idx;
  logic                       f_last;
  logic [tcas_pkg::DrawW-1:0] f_draw;
  logic [QW-1:0]              q_wdata, q_rdata;

  tcas_front #(
    .CarW (CarW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .random_draw_i (random_draw_i),
    .num_cars_i    (cfg_eff.num_cars),
    .full_i        (q_full),
    .push_o        (q_push),
    .car_idx_o     (f_car_idx),
    .last_o        (f_last),
    .draw_o        (f_draw)
  );

  assign q_wdata = {f_car_idx, f_last, f_draw};

  tcas_fifo #(
    .Width (QW),
    .Depth (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  tcas_back #(
    .CarW    (CarW),
    .PosW    (PosW),
    .MaxCars (MAX_CARS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_eff),
    .q_empty_i      (q_empty),
    .q_car_idx_i    (q_rdata[QW-1 -: CarW]),
    .q_last_i       (q_rdata[tcas_pkg::DrawW]),
    .q_draw_i       (q_rdata[tcas_pkg::DrawW-1:0]),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .car_index_o    (car_index_o),
    .new_position_o (new_position_o),
    .new_speed_o    (new_speed_o),
    .sweep_done_o   (sweep_done_o)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// tb: self-checking testbench for traffic_cellular_automaton_step_top.
// Depends on tcas_pkg and the top level; a scoreboard class predicts every
// car update, plain tasks drive the valid/stall channels and the register port.
module tb;

  localparam int MaxCells      = 4096;
  localparam int MaxCars       = 4096;
  localparam int RandomItems   = 650;  // stimulus stops after about this many
  localparam int SettleCycles  = 10;   // pipe is three deep; margin on top
  localparam int HoldOffCycles = 300;  // long receiver hold-off, fills the pipe
  localparam int ReportLimit   = 10;

  // how the two sides pace themselves during a phase
  typedef enum int {
    PaceFree,
    PaceSenderIdle,
    PaceReceiverStall,
    PaceBothIdle
  } pace_e;

  typedef struct {
    logic [tcas_pkg::OutIdxW-1:0] car;
    logic [tcas_pkg::OutPosW-1:0] position;
    logic [tcas_pkg::SpdW-1:0]    speed;
    logic                         last_car;
  } car_update_t;

  // Scoreboard: own copy of road state and registers, predicts each car
  // update when a draw is accepted and checks results in order.
  class ring_road_scoreboard;
    logic [tcas_pkg::LenW-1:0]    track_len;
    logic [tcas_pkg::LenW-1:0]    car_count;
    logic [tcas_pkg::SpdW-1:0]    speed_limit;
    logic [tcas_pkg::PctW-1:0]    slow_pct;
    logic [tcas_pkg::OutPosW-1:0] car_pos [MaxCars];
    logic [tcas_pkg::SpdW-1:0]    car_spd [MaxCars];
    int unsigned                  next_car;
    logic [tcas_pkg::OutPosW-1:0] lead_start_pos;  // car 0 as it was when the sweep began
    car_update_t                  pending_updates [$];
    int unsigned                  mismatches;

    function new();
      track_len   = tcas_pkg::RstTrackLen;
      car_count   = tcas_pkg::RstNumCars;
      speed_limit = tcas_pkg::RstMaxSpeed;
      slow_pct    = tcas_pkg::RstSlowPct;
      for (int i = 0; i < MaxCars; i++) begin
        car_pos[i] = i[tcas_pkg::OutPosW-1:0];
        car_spd[i] = '0;
      end
      next_car       = 0;
      lead_start_pos = '0;
      mismatches     = 0;
    endfunction

    function void set_reg(tcas_pkg::cfg_idx_e idx, logic [tcas_pkg::CfgDataW-1:0] data);
      case (idx)
        tcas_pkg::CfgTrackLen: track_len   = data[tcas_pkg::LenW-1:0];
        tcas_pkg::CfgNumCars:  car_count   = data[tcas_pkg::LenW-1:0];
        tcas_pkg::CfgMaxSpeed: speed_limit = data[tcas_pkg::SpdW-1:0];
        tcas_pkg::CfgSlowPct:  slow_pct    = data[tcas_pkg::PctW-1:0];
        default: ;
      endcase
    endfunction

    // one car update per accepted draw
    function void note_draw(logic [tcas_pkg::DrawW-1:0] draw);
      int unsigned len, cars, j, pos, ahead, gap, v;
      bit          last;
      car_update_t upd;
      len = 32'(track_len);
      if (len < 1) len = 1;
      if (len > MaxCells) len = MaxCells;
      cars = 32'(car_count);
      if (cars < 1) cars = 1;
      if (cars > len) cars = len;
      if (cars > MaxCars) cars = MaxCars;
      // count shrunk under the sweep: start over at car 0
      j = next_car;
      if (j >= cars) j = 0;
      if (j == 0) lead_start_pos = car_pos[0];
      last = (j == cars - 1);
      // stale positions from a longer track are folded back first
      pos   = 32'(car_pos[j]) % len;
      ahead = 32'(last ? lead_start_pos : car_pos[j + 1]) % len;
      if (ahead >= pos + 1) gap = ahead - pos - 1;
      else gap = ahead + len - pos - 1;
      // accelerate, keep distance, random slowdown
      v = 32'(car_spd[j]);
      if (v + 1 <= 32'(speed_limit)) v = v + 1;
      if (gap < v) v = gap;
      if (v > 0 && 32'(draw) + 1 <= 32'(slow_pct)) v = v - 1;
      v   = v & 32'h1f;
      pos = (pos + v) % len;
      car_pos[j] = pos[tcas_pkg::OutPosW-1:0];
      car_spd[j] = v[tcas_pkg::SpdW-1:0];
      next_car   = last ? 0 : j + 1;
      upd.car      = j[tcas_pkg::OutIdxW-1:0];
      upd.position = pos[tcas_pkg::OutPosW-1:0];
      upd.speed    = v[tcas_pkg::SpdW-1:0];
      upd.last_car = last;
      pending_updates.push_back(upd);
    endfunction

    function void check_car_update(car_update_t got);
      car_update_t want;
      if (pending_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("tb: result with no update pending: car %0d pos %0d speed %0d last %0b",
                   got.car, got.position, got.speed, got.last_car);
        return;
      end
      want = pending_updates.pop_front();
      if (got.car !== want.car || got.position !== want.position ||
          got.speed !== want.speed || got.last_car !== want.last_car) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("tb: mismatch at %0t: expected car %0d pos %0d speed %0d last %0b, got car %0d pos %0d speed %0d last %0b",
                   $time, want.car, want.position, want.speed, want.last_car,
                   got.car, got.position, got.speed, got.last_car);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_stall_o;
  logic [tcas_pkg::DrawW-1:0]    random_draw_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i   = 1'b0;
  logic [tcas_pkg::OutIdxW-1:0]  car_index_o;
  logic [tcas_pkg::OutPosW-1:0]  new_position_o;
  logic [tcas_pkg::SpdW-1:0]     new_speed_o;
  logic                          sweep_done_o;
  logic                          cfg_we_i      = 1'b0;
  logic [tcas_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [tcas_pkg::CfgDataW-1:0] cfg_data_i    = '0;

  ring_road_scoreboard sb = new();

  int idle_pct     = 0;  // chance per cycle that the sender holds back
  int stall_pct    = 0;  // chance per cycle that the receiver stalls
  int hold_request = 0;  // main flow asks for a long hold-off here
  int hold_left    = 0;  // counted down by the receiver process
  int random_items = 0;

  traffic_cellular_automaton_step_top #(
    .MAX_CELLS(MaxCells),
    .MAX_CARS (MaxCars)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .random_draw_i (random_draw_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .car_index_o   (car_index_o),
    .new_position_o(new_position_o),
    .new_speed_o   (new_speed_o),
    .sweep_done_o  (sweep_done_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 20 ns clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop; far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: stall decided at the falling edge. A hold-off request takes
  // priority and is counted down here, so the sender keeps pushing into a
  // full pipe and sees in_stall_o rise.
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result transaction: accepted at the rising edge, checked in order.
  always @(posedge clk_i) begin
    car_update_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.car      = car_index_o;
      got.position = new_position_o;
      got.speed    = new_speed_o;
      got.last_car = sweep_done_o;
      sb.check_car_update(got);
    end
  end

  task automatic set_pace(pace_e pace);
    case (pace)
      PaceFree:          begin idle_pct = 0;  stall_pct = 0;  end
      PaceSenderIdle:    begin idle_pct = 86; stall_pct = 0;  end
      PaceReceiverStall: begin idle_pct = 0;  stall_pct = 86; end
      PaceBothIdle:      begin idle_pct = 31; stall_pct = 31; end
      default:           begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Offer one draw; entered and left at a falling edge. Valid stays high
  // between back-to-back transactions, so it is never lowered and raised
  // within one time step.
  task automatic send_item(logic [tcas_pkg::DrawW-1:0] draw);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    random_draw_i <= draw;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_draw(draw);
    @(negedge clk_i);
  endtask

  // Draw mostly in the nominal range, sometimes 100..127.
  task automatic send_random_item();
    logic [tcas_pkg::DrawW-1:0] draw;
    if ($urandom_range(99) < 85) draw = tcas_pkg::DrawW'($urandom_range(99, 0));
    else draw = tcas_pkg::DrawW'($urandom_range(127, 100));
    send_item(draw);
  endtask

  // Stop offering, wait for every result, then let the pipe go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_updates.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(tcas_pkg::cfg_idx_e idx, logic [tcas_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  // All four registers, only once the block is idle. Unused upper data bits
  // of the narrow registers carry junk.
  task automatic apply_setting(logic [tcas_pkg::LenW-1:0] len,
                               logic [tcas_pkg::LenW-1:0] cars,
                               logic [tcas_pkg::SpdW-1:0] spd,
                               logic [tcas_pkg::PctW-1:0] pct);
    logic [31:0]                                   junk_bits;
    logic [tcas_pkg::CfgDataW-tcas_pkg::SpdW-1:0] spd_junk;
    logic [tcas_pkg::CfgDataW-tcas_pkg::PctW-1:0] pct_junk;
    junk_bits = $urandom();
    spd_junk  = junk_bits[tcas_pkg::CfgDataW-tcas_pkg::SpdW-1:0];
    junk_bits = $urandom();
    pct_junk  = junk_bits[tcas_pkg::CfgDataW-tcas_pkg::PctW-1:0];
    settle();
    write_reg(tcas_pkg::CfgTrackLen, len);
    write_reg(tcas_pkg::CfgNumCars, cars);
    write_reg(tcas_pkg::CfgMaxSpeed, {spd_junk, spd});
    write_reg(tcas_pkg::CfgSlowPct, {pct_junk, pct});
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main flow
  // ---------------------------------------------------------------------------
  initial begin
    logic [tcas_pkg::LenW-1:0] len, cars;
    logic [tcas_pkg::SpdW-1:0] spd;
    logic [tcas_pkg::PctW-1:0] pct;
    int                        phase;
    int                        count;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    set_pace(PaceFree);

    // reset settings; slowdown threshold around 25 and out-of-range draws
    send_item(7'd0);
    send_item(7'd24);
    send_item(7'd25);
    send_item(7'd99);
    send_item(7'd100);
    send_item(7'd127);

    // zero length and zero count both read as one; one car on one cell,
    // slow chance above 100
    apply_setting(13'd0, 13'd0, 5'd31, 7'd127);
    send_item(7'd0);
    send_item(7'd127);

    // longest track saturates, single car sees its own old spot ahead
    apply_setting(13'd8191, 13'd1, 5'd31, 7'd0);
    send_item(7'd127);
    send_item(7'd0);
    send_item(7'd64);

    // part of a sweep so next car sits at 4
    apply_setting(13'd60, 13'd6, 5'd31, 7'd0);
    repeat (4) send_item(7'd50);

    // count shrinks below the next car: wraps to car 0; limit under the
    // cars' speeds; slow chance of exactly 100
    apply_setting(13'd60, 13'd3, 5'd1, 7'd100);
    send_item(7'd99);
    send_item(7'd0);

    // shorter track leaves stale positions; count saturates to the length
    apply_setting(13'd3, 13'd8191, 5'd31, 7'd50);
    send_item(7'd49);
    send_item(7'd50);
    send_item(7'd127);

    // everything at the top: count saturates to the full road
    apply_setting(13'd8191, 13'd8191, 5'd31, 7'd25);
    repeat (3) send_item(7'd10);

    // Random phases: pacing rotates through the four modes; settings favor
    // short roads with a few cars so sweeps close often, with the extremes
    // mixed in. State carries across phases, so shrinking roads leave
    // stale positions and lowered limits leave fast cars.
    phase = 0;
    while (random_items < RandomItems) begin
      case ($urandom_range(9))
        0:       len = 13'd0;
        1:       len = 13'd1;
        2:       len = 13'd2;
        3:       len = 13'd8191;
        4:       len = 13'd4096;
        5:       len = tcas_pkg::LenW'($urandom_range(8190, 4097));
        6:       len = tcas_pkg::LenW'($urandom_range(4095, 1024));
        default: len = tcas_pkg::LenW'($urandom_range(64, 3));
      endcase
      case ($urandom_range(7))
        0:       cars = 13'd0;
        1:       cars = 13'd1;
        2:       cars = 13'd8191;
        3:       cars = tcas_pkg::LenW'($urandom_range(8191, 0));
        default: cars = tcas_pkg::LenW'($urandom_range(12, 2));
      endcase
      case ($urandom_range(4))
        0:       spd = 5'd0;
        1:       spd = 5'd31;
        default: spd = tcas_pkg::SpdW'($urandom_range(31, 0));
      endcase
      case ($urandom_range(5))
        0:       pct = 7'd0;
        1:       pct = 7'd100;
        2:       pct = 7'd127;
        default: pct = tcas_pkg::PctW'($urandom_range(100, 0));
      endcase
      apply_setting(len, cars, spd, pct);
      count = $urandom_range(60, 20);
      if (phase == 2) begin
        // sender runs flat out against a long hold-off
        set_pace(PaceFree);
        hold_request = HoldOffCycles;
      end else begin
        set_pace(pace_e'(phase % 4));
      end
      repeat (count) send_random_item();
      random_items += count;
      phase++;
    end

    settle();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_updates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
